// ===== sv/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND_DATA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND_ACK  = 2'd2;

  // Reset values of the sync registers
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST       = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_DATA_RST = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_ACK_RST  = 8'hAF;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHK   = 3'd5
  } phase_t;

  // Emitter states
  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_FETCH = 2'd1,
    B_SHOW  = 2'd2
  } back_state_t;

  // One checked frame waiting to be emitted
  typedef struct packed {
    logic              is_ack;
    logic [BYTE_W-1:0] msg_id;
    logic [LEN_W-1:0]  len;
  } desc_t;

  // Payload store write request from the parser
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [LEN_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== sv/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// Byte parser: sync hunt, header capture, payload store writes, checksum.
// ----------------------------------------------------------------------------
module sfd_front #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]            rx_byte,
  input  logic                                  cfg_valid,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]            cfg_data,
  input  logic                                  q_full,
  input  logic                                  q_wr_slot,
  output logic                                  q_push,
  output sfd_pkg::desc_t                        q_desc,
  output sfd_pkg::mem_wr_t                      mem_wr
);

  sfd_pkg::phase_t               phase, phase_next;
  logic [sfd_pkg::BYTE_W-1:0]    sync_first, sync_second_data, sync_second_ack;
  logic [sfd_pkg::BYTE_W-1:0]    running_sum;
  logic [sfd_pkg::LEN_W-1:0]     byte_count;
  logic [sfd_pkg::LEN_W-1:0]     frame_length;
  logic [sfd_pkg::BYTE_W-1:0]    frame_id;
  logic                          frame_is_ack;
  logic                          take;
  logic                          second_hit;
  logic                          len_ok;
  logic [sfd_pkg::LEN_W-1:0]     count_inc;

  assign in_ready   = !q_full;
  assign take       = in_valid && in_ready;
  assign second_hit = (rx_byte == sync_second_data) || (rx_byte == sync_second_ack);
  assign len_ok     = rx_byte <= sfd_pkg::BYTE_W'(MAX_PAYLOAD);
  assign count_inc  = byte_count + sfd_pkg::LEN_W'(1);

  // Write the sync registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first       <= sfd_pkg::SYNC_FIRST_RST;
      sync_second_data <= sfd_pkg::SYNC_SECOND_DATA_RST;
      sync_second_ack  <= sfd_pkg::SYNC_SECOND_ACK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfd_pkg::REG_SYNC_FIRST:       sync_first       <= cfg_data;
        sfd_pkg::REG_SYNC_SECOND_DATA: sync_second_data <= cfg_data;
        sfd_pkg::REG_SYNC_SECOND_ACK:  sync_second_ack  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        sfd_pkg::PH_SYNC1: begin
          if (rx_byte == sync_first) phase_next = sfd_pkg::PH_SYNC2;
        end
        sfd_pkg::PH_SYNC2: begin
          phase_next = second_hit ? sfd_pkg::PH_ID : sfd_pkg::PH_SYNC1;
        end
        sfd_pkg::PH_ID: phase_next = sfd_pkg::PH_LEN;
        sfd_pkg::PH_LEN: begin
          if (!len_ok)               phase_next = sfd_pkg::PH_SYNC1;
          else if (rx_byte != '0)    phase_next = sfd_pkg::PH_DATA;
          else                       phase_next = sfd_pkg::PH_CHK;
        end
        sfd_pkg::PH_DATA: begin
          if (count_inc >= frame_length) phase_next = sfd_pkg::PH_CHK;
        end
        default: phase_next = sfd_pkg::PH_SYNC1;
      endcase
    end
  end

  // Store writes and descriptor push
  always_comb begin
    mem_wr.en      = take && (phase == sfd_pkg::PH_DATA);
    mem_wr.bank    = q_wr_slot;
    mem_wr.idx     = byte_count;
    mem_wr.data    = rx_byte;
    q_push         = take && (phase == sfd_pkg::PH_CHK) && (running_sum == rx_byte);
    q_desc.is_ack  = frame_is_ack;
    q_desc.msg_id  = frame_id;
    q_desc.len     = frame_length;
  end

  // Advance the phase
  always_ff @(posedge clk) begin
    if (rst) phase <= sfd_pkg::PH_SYNC1;
    else     phase <= phase_next;
  end

  // Track header fields, byte count and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      byte_count   <= '0;
      frame_length <= '0;
      frame_id     <= '0;
      frame_is_ack <= 1'b0;
    end else if (take) begin
      case (phase)
        sfd_pkg::PH_SYNC1: running_sum <= rx_byte;
        sfd_pkg::PH_SYNC2: begin
          running_sum <= running_sum + rx_byte;
          if (second_hit) frame_is_ack <= (rx_byte != sync_second_data);
        end
        sfd_pkg::PH_ID: begin
          running_sum <= running_sum + rx_byte;
          frame_id    <= rx_byte;
        end
        sfd_pkg::PH_LEN: begin
          if (len_ok) begin
            running_sum  <= running_sum + rx_byte;
            frame_length <= rx_byte[sfd_pkg::LEN_W-1:0];
            byte_count   <= '0;
          end
        end
        sfd_pkg::PH_DATA: begin
          running_sum <= running_sum + rx_byte;
          byte_count  <= count_inc;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry queue of checked frame descriptors; slot number picks the bank.
// ----------------------------------------------------------------------------
module sfd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfd_pkg::desc_t  push_desc,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output sfd_pkg::desc_t  head_desc,
  output logic            head_slot,
  output logic            wr_slot
);

  sfd_pkg::desc_t entry [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_desc  = entry[rd_ptr];
  assign head_slot  = rd_ptr;
  assign wr_slot    = wr_ptr;

  // Hold descriptors
  always_ff @(posedge clk) begin
    if (push && !full) entry[wr_ptr] <= push_desc;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full)      wr_ptr <= !wr_ptr;
      if (pop && head_valid)  rd_ptr <= !rd_ptr;
      case ({push && !full, pop && head_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// Payload store and emitter: reads each stored byte and presents a result.
// ----------------------------------------------------------------------------
module sfd_back #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sfd_pkg::mem_wr_t                 mem_wr,
  input  logic                             head_valid,
  input  sfd_pkg::desc_t                   head_desc,
  input  logic                             head_slot,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             is_ack,
  output logic [sfd_pkg::BYTE_W-1:0]       msg_id,
  output logic [sfd_pkg::LEN_W-1:0]        payload_len,
  output logic [sfd_pkg::IDX_W-1:0]        byte_index,
  output logic [sfd_pkg::BYTE_W-1:0]       payload_byte,
  output logic                             last_of_frame
);

  localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = 2 << IW;

  logic [sfd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [sfd_pkg::BYTE_W-1:0] rd_data;
  logic [IW:0]                rd_addr;
  logic [IW-1:0]              idx, idx_next;
  sfd_pkg::back_state_t       state, state_next;
  logic                       shown;
  logic                       is_last;
  logic                       empty_frame;

  assign rd_addr     = {head_slot, idx};
  assign empty_frame = head_desc.len == '0;
  assign is_last     = empty_frame ||
                       ((sfd_pkg::LEN_W'(idx) + sfd_pkg::LEN_W'(1)) == head_desc.len);
  assign shown       = (state == sfd_pkg::B_SHOW) && out_ready;

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[{mem_wr.bank, mem_wr.idx[IW-1:0]}] <= mem_wr.data;
    rd_data <= mem[rd_addr];
  end

  // Next state and byte position
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      sfd_pkg::B_IDLE: begin
        if (head_valid) begin
          state_next = sfd_pkg::B_FETCH;
          idx_next   = '0;
        end
      end
      sfd_pkg::B_FETCH: state_next = sfd_pkg::B_SHOW;
      sfd_pkg::B_SHOW: begin
        if (out_ready) begin
          if (is_last) begin
            state_next = sfd_pkg::B_IDLE;
          end else begin
            state_next = sfd_pkg::B_FETCH;
            idx_next   = idx + IW'(1);
          end
        end
      end
      default: state_next = sfd_pkg::B_IDLE;
    endcase
  end

  // Result fields
  always_comb begin
    out_valid     = state == sfd_pkg::B_SHOW;
    pop           = shown && is_last;
    is_ack        = head_desc.is_ack;
    msg_id        = head_desc.msg_id;
    payload_len   = head_desc.len;
    byte_index    = sfd_pkg::IDX_W'(idx);
    payload_byte  = empty_frame ? '0 : rd_data;
    last_of_frame = is_last;
  end

  // Advance the emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::B_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== sv/sensor_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Serial frame parser with sync hunt, length check and 8-bit sum checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle on the slave side whenever the frame
// queue has room; the queue holds two checked frames, each with its own bank
// of the payload store, so the parser only stalls when two whole frames are
// still waiting to be emitted. The emitter presents one payload byte at a
// time: it puts the payload store address out, then shows the registered
// read data until it is taken on the master side, and only then moves on to
// the next byte. An empty frame gives a single result.
// No clearing pass runs after reset.
module sensor_frame_deframer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Byte input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
  // Result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] msg_id, [13:8] payload_len, [18:14] byte_index,
  // [26:19] payload_byte, [31:27] zero
  output logic [sfd_pkg::TDATA_W-1:0]         m_tdata,
  output logic                                m_tuser,   // [0] is_ack
  output logic                                m_tlast,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]          cfg_data
);

  logic                          q_full, q_push, q_pop, q_head_valid;
  logic                          q_head_slot, q_wr_slot;
  sfd_pkg::desc_t                q_push_desc, q_head_desc;
  sfd_pkg::mem_wr_t              mem_wr;
  logic [sfd_pkg::BYTE_W-1:0]    msg_id, payload_byte;
  logic [sfd_pkg::LEN_W-1:0]     payload_len;
  logic [sfd_pkg::IDX_W-1:0]     byte_index;

  assign cfg_ready = 1'b1;

  sfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .rx_byte   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr_slot (q_wr_slot),
    .q_push    (q_push),
    .q_desc    (q_push_desc),
    .mem_wr    (mem_wr)
  );

  sfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc),
    .head_slot  (q_head_slot),
    .wr_slot    (q_wr_slot)
  );

  sfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk           (clk),
    .rst           (rst),
    .mem_wr        (mem_wr),
    .head_valid    (q_head_valid),
    .head_desc     (q_head_desc),
    .head_slot     (q_head_slot),
    .pop           (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .is_ack        (m_tuser),
    .msg_id        (msg_id),
    .payload_len   (payload_len),
    .byte_index    (byte_index),
    .payload_byte  (payload_byte),
    .last_of_frame (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {5'd0, payload_byte, byte_index, payload_len, msg_id};

endmodule

// ===== sv/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module sfd_checker #(
  parameter int MAX_PAYLOAD = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sfd_pkg::TDATA_W-1:0]   m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);

  logic [5:0] len;
  logic [4:0] idx;
  logic [7:0] pbyte;

  assign len   = m_tdata[13:8];
  assign idx   = m_tdata[18:14];
  assign pbyte = m_tdata[26:19];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // The marked result sits at the end of its frame
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      (len == 6'd0 && idx == 5'd0) ||
      (len != 6'd0 && (6'(idx) + 6'd1) == len) ||
      (len != 6'd0 && MAX_PAYLOAD > 32))
    else $error("last result at wrong position");

  // No frame longer than the store is emitted
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 7'(len) <= 7'(MAX_PAYLOAD))
    else $error("frame length above maximum");

  // An empty frame carries a zero byte and ends at once
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && len == 6'd0 |-> pbyte == 8'd0 && m_tlast)
    else $error("empty frame result malformed");

endmodule

bind sensor_frame_deframer sfd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_sfd_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);
